// ===== sv/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted threshold select block.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int unsigned DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_COMPARE     = 2'd1;
    localparam logic [1:0] REG_REPORT_POS  = 2'd2;

    // compare modes
    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_LE = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;
    localparam logic [1:0] CMP_GE = 2'd3;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

endpackage

// ===== sv/sts_cell.sv =====
// ----------------------------------------------------------------------------
// sts_cell
// One sorting cell: holds a value and its arrival position, compares
// against the incoming key and shifts right on insert, left on drain.
// ----------------------------------------------------------------------------
module sts_cell #(
    parameter int unsigned POS_W = 6
) (
    input  logic                               i_clk,
    input  sts_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [sts_pkg::DATA_W-1:0]  i_key_value,
    input  logic [POS_W-1:0]                   i_key_pos,
    input  logic                               i_valid,
    input  logic                               i_left_valid,
    input  logic                               i_left_gt,
    input  logic signed [sts_pkg::DATA_W-1:0]  i_left_value,
    input  logic [POS_W-1:0]                   i_left_pos,
    input  logic signed [sts_pkg::DATA_W-1:0]  i_right_value,
    input  logic [POS_W-1:0]                   i_right_pos,
    output logic                               o_gt,
    output logic signed [sts_pkg::DATA_W-1:0]  o_value,
    output logic [POS_W-1:0]                   o_pos
);

    logic signed [sts_pkg::DATA_W-1:0] r_value;
    logic [POS_W-1:0]                  r_pos;
    logic signed [sts_pkg::DATA_W-1:0] n_value;
    logic [POS_W-1:0]                  n_pos;

    // strictly greater keeps equal values in arrival order
    assign o_gt = i_valid && (r_value > i_key_value);

    always_comb begin
        n_value = r_value;
        n_pos   = r_pos;
        if (i_ctl.insert) begin
            if (i_left_gt) begin
                n_value = i_left_value;
                n_pos   = i_left_pos;
            end else if ((o_gt || !i_valid) && i_left_valid) begin
                n_value = i_key_value;
                n_pos   = i_key_pos;
            end
        end else if (i_ctl.drain) begin
            n_value = i_right_value;
            n_pos   = i_right_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pos   <= n_pos;
    end

    assign o_value = r_value;
    assign o_pos   = r_pos;

endmodule

// ===== sv/sorted_threshold_select_top.sv =====
// ----------------------------------------------------------------------------
// sorted_threshold_select_top
// Insertion-sorting cell chain with a thresholded, ordered read-out.
// ----------------------------------------------------------------------------
// Usage:
//   A list element is a request taken when start is high and busy is low.
//   Each element is inserted into a chain of MAX_ELEMENTS cells, so a list
//   loads at one element per clock. Elements beyond MAX_ELEMENTS are
//   dropped, but a final mark on them still ends the list.
//   After the final element busy rises and the chain shifts toward cell 0
//   one entry per cycle; cell 0 is compared with the threshold. Busy falls
//   again once the chain is empty. Matching entries come out in ascending
//   value order, each as its value or its arrival position, one per
//   o_result_valid pulse. One match is held back, so the last one is given
//   with end_of_run once the chain is empty. With no match one result with
//   no_match and end_of_run high and a zero word is given. Results are
//   shown for a single cycle; the receiver cannot stall them. The user
//   must write configuration over the APB port only while the block is
//   idle; the block itself does not enforce it. Reset empties the list and
//   clears the registers.
// ----------------------------------------------------------------------------
module sorted_threshold_select_top #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sts_pkg::DATA_W-1:0]  i_element_value,
    input  logic                               i_final_element,
    output logic                               o_result_valid,
    output logic signed [sts_pkg::DATA_W-1:0]  o_result_word,
    output logic                               o_no_match,
    output logic                               o_end_of_run,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int unsigned COUNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned POS_W   = $clog2(MAX_ELEMENTS);
    localparam int unsigned DW      = sts_pkg::DATA_W;

    // configuration
    logic signed [DW-1:0] r_threshold;
    logic [1:0]           r_compare_mode;
    logic                 r_report_pos;
    logic [1:0]           w_reg_index;
    logic                 w_reg_write;

    assign pready      = 1'b1;
    assign w_reg_index = paddr[3:2];
    assign w_reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= '0;
            r_compare_mode <= sts_pkg::CMP_LT;
            r_report_pos   <= 1'b0;
        end else if (w_reg_write) begin
            case (w_reg_index)
                sts_pkg::REG_THRESHOLD:  r_threshold    <= pwdata;
                sts_pkg::REG_COMPARE:    r_compare_mode <= pwdata[1:0];
                sts_pkg::REG_REPORT_POS: r_report_pos   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_index)
            sts_pkg::REG_THRESHOLD:  prdata = r_threshold;
            sts_pkg::REG_COMPARE:    prdata = {30'd0, r_compare_mode};
            sts_pkg::REG_REPORT_POS: prdata = {31'd0, r_report_pos};
            default:                 prdata = 32'd0;
        endcase
    end

    // control
    sts_pkg::t_state    r_state;
    sts_pkg::t_state    n_state;
    logic [COUNT_W-1:0] r_count;
    logic               w_accept;
    logic               w_insert;
    logic               w_head_valid;
    logic               w_head_pass;
    sts_pkg::t_cell_ctl w_ctl;

    logic signed [DW-1:0] w_value [MAX_ELEMENTS];
    logic [POS_W-1:0]     w_pos   [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] w_gt;

    assign busy         = (r_state == sts_pkg::ST_DRAIN);
    assign w_accept     = start && !busy;
    assign w_insert     = w_accept && (r_count < COUNT_W'(MAX_ELEMENTS));
    assign w_head_valid = (r_count != '0);

    always_comb begin
        case (r_compare_mode)
            sts_pkg::CMP_LT: w_head_pass = w_value[0] <  r_threshold;
            sts_pkg::CMP_LE: w_head_pass = w_value[0] <= r_threshold;
            sts_pkg::CMP_GT: w_head_pass = w_value[0] >  r_threshold;
            default:         w_head_pass = w_value[0] >= r_threshold;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sts_pkg::ST_LOAD: begin
                if (w_accept && i_final_element) n_state = sts_pkg::ST_DRAIN;
            end
            sts_pkg::ST_DRAIN: begin
                if (!w_head_valid) n_state = sts_pkg::ST_LOAD;
            end
            default: n_state = sts_pkg::ST_LOAD;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        w_ctl = '0;
        case (r_state)
            sts_pkg::ST_LOAD:  w_ctl.insert = w_insert;
            sts_pkg::ST_DRAIN: w_ctl.drain  = w_head_valid;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sts_pkg::ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_ctl.insert) r_count <= r_count + COUNT_W'(1);
            else if (w_ctl.drain) r_count <= r_count - COUNT_W'(1);
        end
    end

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
            logic                 w_lv;
            logic                 w_lg;
            logic signed [DW-1:0] w_lval;
            logic [POS_W-1:0]     w_lpos;
            logic signed [DW-1:0] w_rval;
            logic [POS_W-1:0]     w_rpos;

            if (gi == 0) begin : g_head
                assign w_lv   = 1'b1;
                assign w_lg   = 1'b0;
                assign w_lval = i_element_value;
                assign w_lpos = r_count[POS_W-1:0];
            end else begin : g_body
                assign w_lv   = (COUNT_W'(gi - 1) < r_count);
                assign w_lg   = w_gt[gi-1];
                assign w_lval = w_value[gi-1];
                assign w_lpos = w_pos[gi-1];
            end

            if (gi == MAX_ELEMENTS - 1) begin : g_tail
                assign w_rval = w_value[gi];
                assign w_rpos = w_pos[gi];
            end else begin : g_mid
                assign w_rval = w_value[gi+1];
                assign w_rpos = w_pos[gi+1];
            end

            sts_cell #(
                .POS_W (POS_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_key_value   (i_element_value),
                .i_key_pos     (r_count[POS_W-1:0]),
                .i_valid       (COUNT_W'(gi) < r_count),
                .i_left_valid  (w_lv),
                .i_left_gt     (w_lg),
                .i_left_value  (w_lval),
                .i_left_pos    (w_lpos),
                .i_right_value (w_rval),
                .i_right_pos   (w_rpos),
                .o_gt          (w_gt[gi]),
                .o_value       (w_value[gi]),
                .o_pos         (w_pos[gi])
            );
        end
    endgenerate

    // read-out: hold one match back so the last one can carry end_of_run
    logic                 r_pend_valid;
    logic signed [DW-1:0] r_pend_word;
    logic                 r_out_valid;
    logic signed [DW-1:0] r_out_word;
    logic                 r_out_nm;
    logic                 r_out_eor;
    logic signed [DW-1:0] w_head_word;

    assign w_head_word = r_report_pos ? {{(DW-POS_W){1'b0}}, w_pos[0]} : w_value[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (busy) begin
                if (w_head_valid) begin
                    if (w_head_pass) begin
                        r_out_valid  <= r_pend_valid;
                        r_pend_valid <= 1'b1;
                    end
                end else begin
                    r_out_valid  <= 1'b1;
                    r_pend_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (busy) begin
            if (w_head_valid) begin
                if (w_head_pass) begin
                    r_out_word  <= r_pend_word;
                    r_out_nm    <= 1'b0;
                    r_out_eor   <= 1'b0;
                    r_pend_word <= w_head_word;
                end
            end else begin
                r_out_word <= r_pend_valid ? r_pend_word : '0;
                r_out_nm   <= !r_pend_valid;
                r_out_eor  <= 1'b1;
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_word  = r_out_word;
    assign o_no_match     = r_out_nm;
    assign o_end_of_run   = r_out_eor;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_ELEMENTS))
        else $error("element count above chain length");

    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == sts_pkg::ST_DRAIN))
        else $error("result strobe outside read-out");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !w_head_valid) |=> (r_out_valid && r_out_eor && !busy))
        else $error("read-out ended without a final result");

    a_no_match_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nm) |-> (r_out_eor && (r_out_word == '0)))
        else $error("no-match result malformed");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && (r_count >= COUNT_W'(2))) |-> (w_value[0] <= w_value[1]))
        else $error("chain head out of order");
`endif

endmodule
